>>> rtl/core/les_pkg.sv
`timescale 1ns / 1ps

package les_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     DIM_RESET     = CFG_W'(8);

  localparam int ELEM_W = 16;
  localparam int SUM_W  = 29;
  localparam int TOT_W  = 30;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LOAD_W = $clog2(DEPTH + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int NBR = 8;
  localparam int K_W = 4;
  localparam logic [K_W-1:0] K_CENTER = K_W'(0);
  localparam logic [K_W-1:0] K_LAST   = K_W'(NBR);

  localparam logic signed [1:0] ROW_STEP [NBR] =
    '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0};
  localparam logic signed [1:0] COL_STEP [NBR] =
    '{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
  } scan_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] max_sum;
    logic signed [SUM_W-1:0] min_sum;
  } scan_res_t;

  function automatic logic [ROW_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] d;
    if (v == CFG_W'(0)) d = ROW_W'(1);
    else if (int'(v) > MAX_ROWS) d = ROW_W'(MAX_ROWS);
    else d = ROW_W'(v);
    return d;
  endfunction

  function automatic logic [COL_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [COL_W-1:0] d;
    if (v == CFG_W'(0)) d = COL_W'(1);
    else if (int'(v) > MAX_COLS) d = COL_W'(MAX_COLS);
    else d = COL_W'(v);
    return d;
  endfunction

  function automatic logic signed [1:0] row_off(input logic [K_W-1:0] k);
    logic [2:0] j;
    logic signed [1:0] d;
    j = 3'(k - K_W'(1));
    if (k == K_CENTER) d = 2'sd0;
    else d = ROW_STEP[j];
    return d;
  endfunction

  function automatic logic signed [1:0] col_off(input logic [K_W-1:0] k);
    logic [2:0] j;
    logic signed [1:0] d;
    j = 3'(k - K_W'(1));
    if (k == K_CENTER) d = 2'sd0;
    else d = COL_STEP[j];
    return d;
  endfunction

endpackage

>>> rtl/core/local_extrema_sum_3x3.sv
// Load: one element per cycle; in_ready drops only during a scan, or for
// the completing element while an earlier result still waits on out_ready.
// Scan: nine reads per cell through the single store read port.
// Reset (rst_n low, synchronous): load count zero, no result pending,
// row_count and col_count back to 8; store contents stay undefined.
`timescale 1ns / 1ps

module local_extrema_sum_3x3 import les_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  out_maxima_sum,
  output logic signed [SUM_W-1:0]  out_minima_sum,
  output logic signed [TOT_W-1:0]  out_extrema_total
);

  typedef enum logic {S_LOAD, S_SCAN} state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        row_count_r;
  logic [CFG_W-1:0]        col_count_r;
  logic [LOAD_W-1:0]       load_count_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] max_sum_r;
  logic signed [SUM_W-1:0] min_sum_r;
  logic signed [TOT_W-1:0] total_sum_r;

  logic [ROW_W-1:0]        rows;
  logic [COL_W-1:0]        cols;
  logic [LOAD_W-1:0]       total;
  logic [LOAD_W-1:0]       count_inc;
  logic                    last_elem;
  logic                    accept;
  scan_cmd_t               cmd;
  scan_res_t               res;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [ELEM_W-1:0] rd_data;

  always_comb begin
    rows      = clamp_rows(row_count_r);
    cols      = clamp_cols(col_count_r);
    total     = LOAD_W'(rows) * LOAD_W'(cols);
    count_inc = load_count_r + LOAD_W'(1);
    last_elem = (count_inc >= total);
    in_ready  = (state_r == S_LOAD) && !(out_valid_r && last_elem);
    accept    = in_valid && in_ready;
    cmd.start = accept && last_elem;
    cmd.rows  = rows;
    cmd.cols  = cols;
  end

  les_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (load_count_r[ADDR_W-1:0]),
    .wr_data (in_element_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  les_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      row_count_r  <= DIM_RESET;
      col_count_r  <= DIM_RESET;
      load_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT: row_count_r <= cfg_data;
          REG_COL_COUNT: col_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        load_count_r <= last_elem ? '0 : count_inc;
      end
      unique case (state_r)
        S_LOAD: if (cmd.start) state_r <= S_SCAN;
        S_SCAN: if (res.done) state_r <= S_LOAD;
        default: state_r <= S_LOAD;
      endcase
      if (res.done) begin
        out_valid_r <= 1'b1;
        max_sum_r   <= res.max_sum;
        min_sum_r   <= res.min_sum;
        total_sum_r <= TOT_W'(res.max_sum) + TOT_W'(res.min_sum);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maxima_sum    = max_sum_r;
  assign out_minima_sum    = min_sum_r;
  assign out_extrema_total = total_sum_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (load_count_r < LOAD_W'(DEPTH)))
    else $error("load count past store depth");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> ((state_r == S_SCAN) && !out_valid_r))
    else $error("scan result without a free output register");

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !out_valid_r)
    else $error("scan started while a result is pending");

endmodule

>>> rtl/core/les_ram.sv
`timescale 1ns / 1ps

module les_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/les_scan.sv
`timescale 1ns / 1ps

module les_scan import les_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scan_cmd_t                cmd,
  output logic [ADDR_W-1:0]        rd_addr,
  input  logic signed [ELEM_W-1:0] rd_data,
  output scan_res_t                res
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t                  state_r;
  logic [RIDX_W-1:0]       row_r;
  logic [CIDX_W-1:0]       col_r;
  logic [K_W-1:0]          k_r;
  logic [ROW_W-1:0]        rows_r;
  logic [COL_W-1:0]        cols_r;
  logic                    tag_v_r;
  logic [K_W-1:0]          tag_k_r;
  logic                    tag_in_r;
  logic signed [ELEM_W-1:0] center_r, center_nxt;
  logic                    is_max_r, is_max_nxt;
  logic                    is_min_r, is_min_nxt;
  logic signed [SUM_W-1:0] acc_max_r, acc_max_nxt;
  logic signed [SUM_W-1:0] acc_min_r, acc_min_nxt;
  logic                    done_r;

  logic signed [ROW_W:0]   nr;
  logic signed [COL_W:0]   nc;
  logic                    inb;
  logic [LOAD_W-1:0]       lin;
  logic                    last_k, last_col, last_cell;

  always_comb begin
    nr = (ROW_W+1)'(signed'({1'b0, row_r})) + (ROW_W+1)'(row_off(k_r));
    nc = (COL_W+1)'(signed'({1'b0, col_r})) + (COL_W+1)'(col_off(k_r));
    inb = !nr[ROW_W] && (nr[ROW_W-1:0] < rows_r) &&
          !nc[COL_W] && (nc[COL_W-1:0] < cols_r);
    lin = LOAD_W'(nr[RIDX_W-1:0]) * LOAD_W'(cols_r) + LOAD_W'(nc[CIDX_W-1:0]);
    rd_addr = lin[ADDR_W-1:0];
    last_k = (k_r == K_LAST);
    last_col = (COL_W'(col_r) == cols_r - COL_W'(1));
    last_cell = last_col && (ROW_W'(row_r) == rows_r - ROW_W'(1));
  end

  always_comb begin
    center_nxt  = center_r;
    is_max_nxt  = is_max_r;
    is_min_nxt  = is_min_r;
    acc_max_nxt = acc_max_r;
    acc_min_nxt = acc_min_r;
    if (tag_k_r == K_CENTER) begin
      center_nxt = rd_data;
      is_max_nxt = 1'b1;
      is_min_nxt = 1'b1;
    end else if (tag_in_r) begin
      if (rd_data > center_r) is_max_nxt = 1'b0;
      if (rd_data < center_r) is_min_nxt = 1'b0;
    end
    if (tag_k_r == K_LAST) begin
      if (is_max_nxt) acc_max_nxt = acc_max_r + SUM_W'(center_r);
      if (is_min_nxt) acc_min_nxt = acc_min_r + SUM_W'(center_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tag_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      tag_v_r  <= (state_r == S_RUN);
      tag_k_r  <= k_r;
      tag_in_r <= inb;
      done_r   <= 1'b0;
      if (tag_v_r) begin
        center_r  <= center_nxt;
        is_max_r  <= is_max_nxt;
        is_min_r  <= is_min_nxt;
        acc_max_r <= acc_max_nxt;
        acc_min_r <= acc_min_nxt;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            rows_r    <= cmd.rows;
            cols_r    <= cmd.cols;
            row_r     <= '0;
            col_r     <= '0;
            k_r       <= K_CENTER;
            acc_max_r <= '0;
            acc_min_r <= '0;
            state_r   <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_k) begin
            k_r <= K_CENTER;
            if (last_cell) begin
              state_r <= S_DRAIN;
            end else if (last_col) begin
              col_r <= '0;
              row_r <= row_r + RIDX_W'(1);
            end else begin
              col_r <= col_r + CIDX_W'(1);
            end
          end else begin
            k_r <= k_r + K_W'(1);
          end
        end
        S_DRAIN: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res.done    = done_r;
  assign res.max_sum = acc_max_r;
  assign res.min_sum = acc_min_r;

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (k_r <= K_LAST))
    else $error("neighbor step out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("scan done held longer than one cycle");

  a_center_inb: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_v_r && (tag_k_r == K_CENTER)) |-> tag_in_r)
    else $error("center read out of bounds");

endmodule
